### rtl/core/cvm_pkg.sv
// ----------------------------------------------------------------------------
// Cell voltage monitor package
// Shared widths, register indexes, reset values, flag positions and the
// structs that carry settings and step controls between the modules.
// ----------------------------------------------------------------------------
package cvm_pkg;

  localparam int VOLT_W         = 16;
  localparam int ALERT_W        = 3;
  localparam int FLAG_W         = 6;
  localparam int DLY_FIELD_W    = 8;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 48;
  localparam int BAL_LIM_W      = 48;
  localparam int DELAYS_W       = 32;

  localparam int CELL_COUNT_DEF = 4;
  localparam int DELAY_BITS_DEF = 8;

  // Bit positions inside a cell's flags and alert vectors.
  localparam int FLAG_OVC = 0;
  localparam int FLAG_OVT = 1;
  localparam int FLAG_UV  = 2;
  localparam int FLAG_MAX = 3;
  localparam int FLAG_MIN = 4;
  localparam int FLAG_BAL = 5;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_OVC_SET    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OVC_CLR    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OVT_SET    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OVT_CLR    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UV_SET     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_UV_CLR     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BAL_LIMITS = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAYS     = 3'd7;

  localparam logic [VOLT_W-1:0]    RST_OVC_SET    = 16'd4200;
  localparam logic [VOLT_W-1:0]    RST_OVC_CLR    = 16'd4100;
  localparam logic [VOLT_W-1:0]    RST_OVT_SET    = 16'd4300;
  localparam logic [VOLT_W-1:0]    RST_OVT_CLR    = 16'd4150;
  localparam logic [VOLT_W-1:0]    RST_UV_SET     = 16'd2800;
  localparam logic [VOLT_W-1:0]    RST_UV_CLR     = 16'd3000;
  localparam logic [BAL_LIM_W-1:0] RST_BAL_LIMITS = 48'd16750621491220;
  localparam logic [DELAYS_W-1:0]  RST_DELAYS     = 32'd84018442;

  typedef struct packed {
    logic [VOLT_W-1:0]      ovc_set;
    logic [VOLT_W-1:0]      ovc_clr;
    logic [VOLT_W-1:0]      ovt_set;
    logic [VOLT_W-1:0]      ovt_clr;
    logic [VOLT_W-1:0]      uv_set;
    logic [VOLT_W-1:0]      uv_clr;
    logic [DLY_FIELD_W-1:0] dly_ovc;
    logic [DLY_FIELD_W-1:0] dly_ovt;
    logic [DLY_FIELD_W-1:0] dly_uv;
  } cvm_alert_cfg_t;

  typedef struct packed {
    logic [VOLT_W-1:0]      on_th;
    logic [VOLT_W-1:0]      rec;
    logic [VOLT_W-1:0]      dmin;
    logic [DLY_FIELD_W-1:0] dly_bal;
  } cvm_bal_cfg_t;

  // A stage load: meas for a measurement request, tick for a timer tick.
  typedef struct packed {
    logic meas;
    logic tick;
  } cvm_step_t;

endpackage

### rtl/core/cvm_lane.sv
// ----------------------------------------------------------------------------
// Cell lane
// Derives one cell voltage from two adjacent taps and runs the three
// hysteretic alerts of that cell with their delay timers.
// ----------------------------------------------------------------------------
module cvm_lane #(
  parameter int DELAY_BITS = cvm_pkg::DELAY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cvm_pkg::cvm_step_t             step,
  input  cvm_pkg::cvm_alert_cfg_t        cfg,
  input  logic [cvm_pkg::VOLT_W-1:0]     tap,
  input  logic [cvm_pkg::VOLT_W-1:0]     tap_below,
  output logic [cvm_pkg::VOLT_W-1:0]     volts,
  output logic [cvm_pkg::ALERT_W-1:0]    status
);
  import cvm_pkg::*;

  logic [VOLT_W-1:0]     volts_r, volts_nxt;
  logic [VOLT_W-1:0]     diff;
  logic [ALERT_W-1:0]    alert_r, alert_nxt;
  logic [ALERT_W-1:0]    status_r, status_nxt;
  logic [ALERT_W-1:0]    set_c, clr_c;
  logic [DELAY_BITS-1:0] dly_r   [ALERT_W];
  logic [DELAY_BITS-1:0] dly_nxt [ALERT_W];
  logic [DELAY_BITS-1:0] reload  [ALERT_W];

  assign diff = (tap > tap_below) ? (tap - tap_below) : '0;

  assign set_c[FLAG_OVC] = diff > cfg.ovc_set;
  assign clr_c[FLAG_OVC] = diff < cfg.ovc_clr;
  assign set_c[FLAG_OVT] = diff > cfg.ovt_set;
  assign clr_c[FLAG_OVT] = diff < cfg.ovt_clr;
  assign set_c[FLAG_UV]  = diff < cfg.uv_set;
  assign clr_c[FLAG_UV]  = diff > cfg.uv_clr;

  assign reload[FLAG_OVC] = DELAY_BITS'(cfg.dly_ovc);
  assign reload[FLAG_OVT] = DELAY_BITS'(cfg.dly_ovt);
  assign reload[FLAG_UV]  = DELAY_BITS'(cfg.dly_uv);

  assign volts_nxt = step.meas ? diff : volts_r;

  // The set test runs before the clear test, so with inverted levels both can
  // fire in one request and each reloads the timer. The visible status follows
  // the alert only once its timer has run out.
  always_comb begin
    alert_nxt  = alert_r;
    status_nxt = status_r;
    for (int k = 0; k < ALERT_W; k++) begin
      dly_nxt[k] = dly_r[k];
      if (step.tick) begin
        if (dly_r[k] != '0) begin
          dly_nxt[k] = dly_r[k] - DELAY_BITS'(1);
        end
      end else if (step.meas) begin
        if (set_c[k] && !alert_nxt[k]) begin
          alert_nxt[k] = 1'b1;
          dly_nxt[k]   = reload[k];
        end
        if (clr_c[k] && alert_nxt[k]) begin
          alert_nxt[k] = 1'b0;
          dly_nxt[k]   = reload[k];
        end
        if (dly_nxt[k] == '0) begin
          status_nxt[k] = alert_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volts_r  <= '0;
      alert_r  <= '0;
      status_r <= '0;
      for (int k = 0; k < ALERT_W; k++) begin
        dly_r[k] <= '0;
      end
    end else begin
      volts_r  <= volts_nxt;
      alert_r  <= alert_nxt;
      status_r <= status_nxt;
      for (int k = 0; k < ALERT_W; k++) begin
        dly_r[k] <= dly_nxt[k];
      end
    end
  end

  assign volts  = volts_r;
  assign status = status_r;

`ifndef SYNTHESIS
  a_tick_keeps_status: assert property (@(posedge clk) disable iff (!rst_n)
    step.tick |=> $stable(status_r) && $stable(volts_r) && $stable(alert_r))
    else $error("cell lane: tick changed voltage or alert state");

  a_idle_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step.meas && !step.tick |=> $stable(status_r) && $stable(volts_r))
    else $error("cell lane: state moved without a request");
`endif

endmodule

### rtl/core/cvm_merge.sv
// ----------------------------------------------------------------------------
// Lane merge and balancing
// Finds the maximum and minimum cell through a compare tree (a tie goes to the
// lower index), then drives the passive balancing switches with their timers.
// The second stage register is the result register.
// ----------------------------------------------------------------------------
module cvm_merge #(
  parameter int CELL_COUNT = cvm_pkg::CELL_COUNT_DEF,
  parameter int DELAY_BITS = cvm_pkg::DELAY_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  cvm_pkg::cvm_step_t                             ld_mm,
  input  cvm_pkg::cvm_step_t                             ld_bal,
  input  cvm_pkg::cvm_bal_cfg_t                          cfg,
  input  logic [CELL_COUNT-1:0][cvm_pkg::VOLT_W-1:0]     volts_in,
  input  logic [CELL_COUNT-1:0][cvm_pkg::ALERT_W-1:0]    alert_in,
  output logic [CELL_COUNT-1:0][cvm_pkg::VOLT_W-1:0]     volts_out,
  output logic [CELL_COUNT-1:0][cvm_pkg::FLAG_W-1:0]     flags_out,
  output logic [CELL_COUNT-1:0]                          bleed_out
);
  import cvm_pkg::*;

  localparam int IDX_W  = $clog2(CELL_COUNT);
  localparam int LEAVES = 1 << IDX_W;

  // Heap-ordered compare trees: node k combines nodes 2k and 2k+1.
  logic [VOLT_W-1:0] hi_v [1:2*LEAVES-1];
  logic [VOLT_W-1:0] lo_v [1:2*LEAVES-1];
  logic [IDX_W-1:0]  hi_i [1:2*LEAVES-1];
  logic [IDX_W-1:0]  lo_i [1:2*LEAVES-1];
  logic [CELL_COUNT-1:0] mx_oh, mn_oh;

  // Min/max stage.
  logic [CELL_COUNT-1:0][VOLT_W-1:0]  vol2_r;
  logic [CELL_COUNT-1:0][ALERT_W-1:0] alt2_r;
  logic [CELL_COUNT-1:0]              mxf_r, mnf_r;
  logic [VOLT_W-1:0]                  vmin_r;

  // Balancing and result stage.
  logic [CELL_COUNT-1:0][VOLT_W-1:0]  vol3_r;
  logic [CELL_COUNT-1:0][ALERT_W-1:0] alt3_r;
  logic [CELL_COUNT-1:0]              mx3_r, mn3_r;
  logic [CELL_COUNT-1:0]              bal_r, bal_nxt;
  logic [DELAY_BITS-1:0]              bdly_r   [CELL_COUNT];
  logic [DELAY_BITS-1:0]              bdly_nxt [CELL_COUNT];
  logic [VOLT_W-1:0]                  delta    [CELL_COUNT];
  logic [DELAY_BITS-1:0]              bal_reload;

  // Padding leaves can never win: a tie keeps the left (lower) index, and
  // the padding values are never strictly above or below a real cell.
  always_comb begin
    for (int j = 0; j < LEAVES; j++) begin
      if (j < CELL_COUNT) begin
        hi_v[LEAVES+j] = volts_in[j];
        lo_v[LEAVES+j] = volts_in[j];
      end else begin
        hi_v[LEAVES+j] = '0;
        lo_v[LEAVES+j] = '1;
      end
      hi_i[LEAVES+j] = IDX_W'(j);
      lo_i[LEAVES+j] = IDX_W'(j);
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      if (hi_v[2*k+1] > hi_v[2*k]) begin
        hi_v[k] = hi_v[2*k+1];
        hi_i[k] = hi_i[2*k+1];
      end else begin
        hi_v[k] = hi_v[2*k];
        hi_i[k] = hi_i[2*k];
      end
      if (lo_v[2*k+1] < lo_v[2*k]) begin
        lo_v[k] = lo_v[2*k+1];
        lo_i[k] = lo_i[2*k+1];
      end else begin
        lo_v[k] = lo_v[2*k];
        lo_i[k] = lo_i[2*k];
      end
    end
    for (int i = 0; i < CELL_COUNT; i++) begin
      mx_oh[i] = (hi_i[1] == IDX_W'(i));
      mn_oh[i] = (lo_i[1] == IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mxf_r <= '0;
      mnf_r <= '0;
    end else if (ld_mm.meas) begin
      mxf_r <= mx_oh;
      mnf_r <= mn_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_mm.meas) begin
      vmin_r <= lo_v[1];
    end
    if (ld_mm.meas || ld_mm.tick) begin
      vol2_r <= volts_in;
      alt2_r <= alert_in;
    end
  end

  assign bal_reload = DELAY_BITS'(cfg.dly_bal);

  // The on test reloads the timer first; the off test then sees that timer,
  // so a zero balance delay switches a cell off in the same request.
  always_comb begin
    bal_nxt = bal_r;
    for (int i = 0; i < CELL_COUNT; i++) begin
      delta[i]    = vol2_r[i] - vmin_r;
      bdly_nxt[i] = bdly_r[i];
      if (ld_bal.tick) begin
        if (bdly_r[i] != '0) begin
          bdly_nxt[i] = bdly_r[i] - DELAY_BITS'(1);
        end
      end else if (ld_bal.meas) begin
        if (vol2_r[i] > cfg.on_th && delta[i] >= cfg.dmin) begin
          bdly_nxt[i] = bal_reload;
          bal_nxt[i]  = 1'b1;
        end
        if (vol2_r[i] < cfg.rec || delta[i] < cfg.dmin || bdly_nxt[i] == '0) begin
          bal_nxt[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_r <= '0;
      for (int i = 0; i < CELL_COUNT; i++) begin
        bdly_r[i] <= '0;
      end
    end else begin
      bal_r <= bal_nxt;
      for (int i = 0; i < CELL_COUNT; i++) begin
        bdly_r[i] <= bdly_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_bal.meas || ld_bal.tick) begin
      vol3_r <= vol2_r;
      alt3_r <= alt2_r;
      mx3_r  <= mxf_r;
      mn3_r  <= mnf_r;
    end
  end

  always_comb begin
    for (int i = 0; i < CELL_COUNT; i++) begin
      flags_out[i][FLAG_UV:FLAG_OVC] = alt3_r[i];
      flags_out[i][FLAG_MAX]         = mx3_r[i];
      flags_out[i][FLAG_MIN]         = mn3_r[i];
      flags_out[i][FLAG_BAL]         = bal_r[i];
    end
  end

  assign volts_out = vol3_r;
  assign bleed_out = bal_r;

`ifndef SYNTHESIS
  a_one_max_one_min: assert property (@(posedge clk) disable iff (!rst_n)
    ld_mm.meas |=> $onehot(mxf_r) && $onehot(mnf_r))
    else $error("merge: maximum or minimum flag is not unique after a measurement");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ld_bal.meas && !ld_bal.tick |=> $stable(bal_r) && $stable(vol3_r))
    else $error("merge: result register moved without a load");
`endif

endmodule

### rtl/core/cell_voltage_monitor_balancer.sv
// ----------------------------------------------------------------------------
// Cell voltage monitor and passive balancer
// Stack tap measurements in, per-cell voltages, protection flags and
// balancing switch drive out, one result per request.
//
// The in_ channel takes one request per accepted beat: in_tuser low is a
// measurement with the stacked taps in in_tdata, in_tuser high is a
// one-second tick that only moves the delay timers. Every request gives one
// result on the out_ channel, in order. Registers are to be written through
// the cfg_ port while no request is in flight; the block does not check it.
// An accepted request passes through three register stages in order: the
// cell lanes (tap difference and alerts), the min/max compare tree and the
// balancing stage, which holds the result. One request is taken every cycle
// while the receiver takes results. Reset clears the lane voltages, alerts
// and timers, the min/max flags and the balancing switches and timers and
// loads the default thresholds; the result register's voltages, alert and
// min/max flags are not cleared. No result is pending afterwards. A stalled
// receiver holds the result register, and the stages behind it fill up.
// ----------------------------------------------------------------------------
module cell_voltage_monitor_balancer #(
  parameter int  CELL_COUNT = cvm_pkg::CELL_COUNT_DEF,
  parameter int  DELAY_BITS = cvm_pkg::DELAY_BITS_DEF,
  localparam int IN_W       = CELL_COUNT * cvm_pkg::VOLT_W,
  localparam int OUT_BITS   = CELL_COUNT * (cvm_pkg::VOLT_W + cvm_pkg::FLAG_W + 1),
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_W-1:0]                  in_tdata,   // tap_one, tap_two, ...
  input  logic                             in_tuser,   // mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_W-1:0]                 out_tdata,  // volts_*, flags_*, bleed_enable
  input  logic                             cfg_we,
  input  logic [cvm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cvm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cvm_pkg::*;

  logic [VOLT_W-1:0]    ovc_set_r, ovc_clr_r, ovt_set_r, ovt_clr_r, uv_set_r, uv_clr_r;
  logic [BAL_LIM_W-1:0] bal_lim_r;
  logic [DELAYS_W-1:0]  delays_r;
  cvm_alert_cfg_t       acfg;
  cvm_bal_cfg_t         bcfg;

  logic s1_vld_r, s1_mode_r, s2_vld_r, s2_mode_r, out_vld_r;
  logic rdy2, rdy3, in_fire;
  cvm_step_t st1, st2, st3;

  logic [CELL_COUNT-1:0][VOLT_W-1:0]  taps, below;
  logic [CELL_COUNT-1:0][VOLT_W-1:0]  volts_s1, volts_res;
  logic [CELL_COUNT-1:0][ALERT_W-1:0] alert_s1;
  logic [CELL_COUNT-1:0][FLAG_W-1:0]  flags_res;
  logic [CELL_COUNT-1:0]              bleed_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovc_set_r <= RST_OVC_SET;
      ovc_clr_r <= RST_OVC_CLR;
      ovt_set_r <= RST_OVT_SET;
      ovt_clr_r <= RST_OVT_CLR;
      uv_set_r  <= RST_UV_SET;
      uv_clr_r  <= RST_UV_CLR;
      bal_lim_r <= RST_BAL_LIMITS;
      delays_r  <= RST_DELAYS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OVC_SET:    ovc_set_r <= cfg_wdata[VOLT_W-1:0];
        REG_OVC_CLR:    ovc_clr_r <= cfg_wdata[VOLT_W-1:0];
        REG_OVT_SET:    ovt_set_r <= cfg_wdata[VOLT_W-1:0];
        REG_OVT_CLR:    ovt_clr_r <= cfg_wdata[VOLT_W-1:0];
        REG_UV_SET:     uv_set_r  <= cfg_wdata[VOLT_W-1:0];
        REG_UV_CLR:     uv_clr_r  <= cfg_wdata[VOLT_W-1:0];
        REG_BAL_LIMITS: bal_lim_r <= cfg_wdata[BAL_LIM_W-1:0];
        REG_DELAYS:     delays_r  <= cfg_wdata[DELAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    acfg.ovc_set = ovc_set_r;
    acfg.ovc_clr = ovc_clr_r;
    acfg.ovt_set = ovt_set_r;
    acfg.ovt_clr = ovt_clr_r;
    acfg.uv_set  = uv_set_r;
    acfg.uv_clr  = uv_clr_r;
    acfg.dly_ovc = delays_r[31:24];
    acfg.dly_ovt = delays_r[23:16];
    acfg.dly_uv  = delays_r[15:8];
    bcfg.on_th   = bal_lim_r[47:32];
    bcfg.rec     = bal_lim_r[31:16];
    bcfg.dmin    = bal_lim_r[15:0];
    bcfg.dly_bal = delays_r[7:0];
  end

  // Each stage takes a new request when it is empty or its content moves on.
  assign rdy3      = !out_vld_r || out_tready;
  assign rdy2      = !s2_vld_r || rdy3;
  assign in_tready = !s1_vld_r || rdy2;
  assign in_fire   = in_tvalid && in_tready;

  assign st1.meas = in_fire && !in_tuser;
  assign st1.tick = in_fire && in_tuser;
  assign st2.meas = s1_vld_r && rdy2 && !s1_mode_r;
  assign st2.tick = s1_vld_r && rdy2 && s1_mode_r;
  assign st3.meas = s2_vld_r && rdy3 && !s2_mode_r;
  assign st3.tick = s2_vld_r && rdy3 && s2_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_fire || (s1_vld_r && !rdy2);
      s2_vld_r  <= (s1_vld_r && rdy2) || (s2_vld_r && !rdy3);
      out_vld_r <= (s2_vld_r && rdy3) || (out_vld_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser;
    end
    if (s1_vld_r && rdy2) begin
      s2_mode_r <= s1_mode_r;
    end
  end

  // Cell one is measured against ground.
  assign taps = in_tdata;
  always_comb begin
    below[0] = '0;
    for (int i = 1; i < CELL_COUNT; i++) begin
      below[i] = taps[i-1];
    end
  end

  for (genvar g = 0; g < CELL_COUNT; g++) begin : g_lane
    cvm_lane #(
      .DELAY_BITS (DELAY_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (st1),
      .cfg       (acfg),
      .tap       (taps[g]),
      .tap_below (below[g]),
      .volts     (volts_s1[g]),
      .status    (alert_s1[g])
    );
  end

  cvm_merge #(
    .CELL_COUNT (CELL_COUNT),
    .DELAY_BITS (DELAY_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_mm     (st2),
    .ld_bal    (st3),
    .cfg       (bcfg),
    .volts_in  (volts_s1),
    .alert_in  (alert_s1),
    .volts_out (volts_res),
    .flags_out (flags_res),
    .bleed_out (bleed_res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({bleed_res, flags_res, volts_res});

endmodule
